[hw/rtl/lattice_boltzmann_bgk_collision_unit_macros.svh]
// Assertion macros for the BGK collision unit.
`ifndef LATTICE_BOLTZMANN_BGK_COLLISION_UNIT_MACROS_SVH
`define LATTICE_BOLTZMANN_BGK_COLLISION_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define LBM_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LBM_ASSERT(label, clk, rst, prop)
`define LBM_ASSERT_RST(label, clk, prop)
`endif
`endif

[hw/rtl/lbm_bgk_pkg.sv]
// Shared constants for the BGK collision unit.
package lbm_bgk_pkg;
   localparam int FracBits = 16;
   localparam int NumDir = 9;
   localparam int CsrAddrWidth = 1;
   localparam logic [CsrAddrWidth-1:0] RegRelaxRate = 1'b0;
   localparam int signed DirCx [NumDir] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   localparam int signed DirCy [NumDir] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
endpackage

[hw/rtl/lbm_bgk_if.sv]
// Valid/ready channel interface.
interface lbm_bgk_if #(parameter int Width = 1) (input logic clock);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/lbm_bgk_lane.sv]
// One direction lane: equilibrium and relaxation, pipelined.
module lbm_bgk_lane #(
   parameter int FracBits = 16,
   parameter int Cx = 0,
   parameter int Cy = 0,
   parameter int WNum = 1,
   parameter int WDen = 9
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [FracBits:0]          f,
   input  logic [FracBits+4:0]        rho,
   input  logic signed [FracBits+1:0] ux,
   input  logic signed [FracBits+1:0] uy,
   input  logic [FracBits+1:0]        omega,
   output logic signed [FracBits+1:0] post
);
   localparam longint One = 64'sd1 << FracBits;
   localparam longint Dv = longint'(WDen) << FracBits;
   // WDen is 9 or 36: floor by 2^(FracBits+WShift) first, then by 9
   localparam int WShift = (WDen == 36) ? 2 : 0;
   localparam logic signed [31:0] Recip9 = 32'sd477218589;  // ceil(2^32 / 9)
   typedef logic signed [63:0] s64_type;
   typedef logic signed [31:0] s32_type;

   s32_type e_ff, poly_ff, feq_ff, d_ff;
   s64_type usq_ff, prod_ff, rel_ff;
   logic [FracBits:0] f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff;
   logic [FracBits+4:0] rho1_ff, rho2_ff;
   logic [FracBits+1:0] om1_ff, om2_ff, om3_ff, om4_ff;
   logic signed [FracBits+1:0] post_ff, post_in;
   s64_type e_in, poly_in, num, mq, q0, feq_in, post_v;
   s32_type nq;

   always_comb begin
      e_in = s64_type'(Cx) * s64_type'(ux) + s64_type'(Cy) * s64_type'(uy);
      poly_in = One + 3 * e_ff + ((9 * e_ff * e_ff - 3 * usq_ff + One) >>> (FracBits + 1));
      num = prod_ff + Dv / 2;
      nq = s32_type'(num >>> (FracBits + WShift));
      mq = nq * Recip9;
      q0 = mq >>> 32;
      feq_in = q0;
      if ((q0 + 1) * 9 <= s64_type'(nq)) feq_in = q0 + 1;
      else if (q0 * 9 > s64_type'(nq)) feq_in = q0 - 1;
      post_v = s64_type'(f6_ff) + ((rel_ff + One / 2) >>> FracBits);
      if (post_v > 2 * One - 1) post_in = (FracBits + 2)'(2 * One - 1);
      else if (post_v < -2 * One) post_in = (FracBits + 2)'(-2 * One);
      else post_in = post_v[FracBits+1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in[31:0];
         usq_ff <= ux * ux + uy * uy;
         f1_ff <= f; rho1_ff <= rho; om1_ff <= omega;
         poly_ff <= poly_in[31:0]; f2_ff <= f1_ff; rho2_ff <= rho1_ff; om2_ff <= om1_ff;
         prod_ff <= s64_type'(WNum) * $signed({1'b0, rho2_ff}) * poly_ff;
         f3_ff <= f2_ff; om3_ff <= om2_ff;
         feq_ff <= feq_in[31:0]; f4_ff <= f3_ff; om4_ff <= om3_ff;
         d_ff <= feq_ff - s32_type'(f4_ff); f5_ff <= f4_ff;
         rel_ff <= $signed({1'b0, om4_ff}) * d_ff; f6_ff <= f5_ff;
         post_ff <= post_in;
      end
   end
   assign post = post_ff;
endmodule

[hw/rtl/lbm_bgk_moments.sv]
// Density, momentum and radix-2 restoring velocity division, pipelined.
module lbm_bgk_moments #(
   parameter int FracBits = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [9*(FracBits+1)-1:0]  f_flat,
   output logic [FracBits+4:0]        rho,
   output logic signed [FracBits+1:0] ux,
   output logic signed [FracBits+1:0] uy
);
   import lbm_bgk_pkg::*;
   localparam int QB = FracBits + 6;
   localparam int NS = QB;
   localparam int RW = FracBits + 6;
   typedef logic signed [63:0] s64_type;

   logic [FracBits+4:0] drho_ff [NS+1];
   logic [RW+QB:0] rx_ff [NS+1], ry_ff [NS+1];
   logic [QB-1:0] qx_ff [NS+1], qy_ff [NS+1];
   logic sx_ff [NS+1], sy_ff [NS+1];
   logic [FracBits+4:0] rho_o_ff;
   s64_type vx_ff, vy_ff;

   s64_type mx, my;
   logic [FracBits+4:0] rsum;
   always_comb begin
      rsum = '0; mx = 0; my = 0;
      for (int q = 0; q < 9; q++) begin
         rsum = rsum + (FracBits + 5)'(f_flat[q*(FracBits+1) +: FracBits+1]);
         mx = mx + s64_type'(DirCx[q]) * s64_type'(f_flat[q*(FracBits+1) +: FracBits+1]);
         my = my + s64_type'(DirCy[q]) * s64_type'(f_flat[q*(FracBits+1) +: FracBits+1]);
      end
   end

   function automatic s64_type fin(input logic [QB-1:0] qq, input logic [RW+QB:0] r,
                                   input logic [FracBits+4:0] d, input logic s);
      s64_type v;
      v = s64_type'(qq);
      if (2 * s64_type'(r[RW+1:0]) >= s64_type'(d)) begin
         // rounding: ties to +inf; negatives need strictly greater
         if (!s || 2 * s64_type'(r[RW+1:0]) > s64_type'(d)) v = v + 1;
      end
      if (s) v = -v;
      if (d == '0) v = 0;
      if (v > (64'sd1 << (FracBits + 1)) - 1) v = (64'sd1 << (FracBits + 1)) - 1;
      if (v < -(64'sd1 << (FracBits + 1))) v = -(64'sd1 << (FracBits + 1));
      return v;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         drho_ff[0] <= rsum;
         sx_ff[0] <= mx < 0; sy_ff[0] <= my < 0;
         rx_ff[0] <= (RW + QB + 1)'((mx < 0 ? -mx : mx) << FracBits);
         ry_ff[0] <= (RW + QB + 1)'((my < 0 ? -my : my) << FracBits);
         qx_ff[0] <= '0; qy_ff[0] <= '0;
         for (int s = 0; s < NS; s++) begin
            drho_ff[s+1] <= drho_ff[s];
            sx_ff[s+1] <= sx_ff[s]; sy_ff[s+1] <= sy_ff[s];
            if ((rx_ff[s] >> (QB - 1 - s)) >= (RW + QB + 1)'(drho_ff[s])) begin
               rx_ff[s+1] <= rx_ff[s] - ((RW + QB + 1)'(drho_ff[s]) << (QB - 1 - s));
               qx_ff[s+1] <= qx_ff[s] | (QB'(1) << (QB - 1 - s));
            end else begin
               rx_ff[s+1] <= rx_ff[s]; qx_ff[s+1] <= qx_ff[s];
            end
            if ((ry_ff[s] >> (QB - 1 - s)) >= (RW + QB + 1)'(drho_ff[s])) begin
               ry_ff[s+1] <= ry_ff[s] - ((RW + QB + 1)'(drho_ff[s]) << (QB - 1 - s));
               qy_ff[s+1] <= qy_ff[s] | (QB'(1) << (QB - 1 - s));
            end else begin
               ry_ff[s+1] <= ry_ff[s]; qy_ff[s+1] <= qy_ff[s];
            end
         end
         vx_ff <= fin(qx_ff[NS], rx_ff[NS], drho_ff[NS], sx_ff[NS]);
         vy_ff <= fin(qy_ff[NS], ry_ff[NS], drho_ff[NS], sy_ff[NS]);
         rho_o_ff <= drho_ff[NS];
      end
   end
   assign rho = rho_o_ff;
   assign ux = vx_ff[FracBits+1:0];
   assign uy = vy_ff[FracBits+1:0];
endmodule

[hw/rtl/lattice_boltzmann_bgk_collision_unit.sv]
// Top level of the D2Q9 BGK collision unit.
// Usage:
//  - req channel: one beat carries a cell's nine distributions (17-bit Q1.16).
//  - rsp channel: one beat carries nine post-collision values, density, velocity.
//  - csr port: APB-style, register 0 is relax_rate (omega, Q2.16), reset 1.0.
// Throughput: one cell per clock while the receiver does not stall. The pipeline is a chain of register stages
// (sum, one divider stage per quotient bit, rounding, then the nine direction lanes).
// The division is bit-serial, unrolled over stages, one quotient bit per stage.
// Stalls: the whole pipeline advances only when its last stage is free or
// being read, so a stalled receiver freezes every stage; req_ready falls then.
// Reset: synchronous, active high; clears the valid bits and sets omega to 1.0.
// Results leave in the order the cells arrived; none is dropped or repeated.
// The velocity division takes FracBits+6 stages; each lane uses a reciprocal
// multiply with a one-step correction for the weight division.
// Zero density gives zero velocity.
module lattice_boltzmann_bgk_collision_unit #(
   parameter int FracBits = lbm_bgk_pkg::FracBits
) (
   input  logic clock,
   input  logic reset,
   lbm_bgk_if.sink   req,
   lbm_bgk_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [lbm_bgk_pkg::CsrAddrWidth+1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lbm_bgk_pkg::*;
`include "lattice_boltzmann_bgk_collision_unit_macros.svh"
   localparam int FW = FracBits + 1;
   localparam int PW = FracBits + 2;
   localparam int Lat = 2 + FracBits + 6 + 7;

   logic [PW-1:0] relax_ff;
   logic [Lat-1:0] vld_ff;
   logic en;

   // CSR
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) relax_ff <= PW'(64'd1 << FracBits);
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr[CsrAddrWidth+1:2] == RegRelaxRate) relax_ff <= csr_pwdata[PW-1:0];
   end
   assign csr_prdata = (csr_paddr[CsrAddrWidth+1:2] == RegRelaxRate) ? 32'(relax_ff) : '0;

   // Pipeline advance
   assign en = !vld_ff[Lat-1] || rsp.ready;
   assign req.ready = en;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Lat-2:0], req.valid};
   end

   logic [FracBits+4:0] rho;
   logic signed [PW-1:0] ux, uy;
   lbm_bgk_moments #(.FracBits(FracBits)) u_mom (
      .clock(clock), .en(en), .f_flat(req.data[9*FW-1:0]), .rho(rho), .ux(ux), .uy(uy));

   // Align each f to the moments output.
   localparam int MD = FracBits + 8;
   logic [9*FW-1:0] fd_ff [MD];
   always_ff @(posedge clock) begin
      if (en) begin
         fd_ff[0] <= req.data[9*FW-1:0];
         for (int i = 1; i < MD; i++) fd_ff[i] <= fd_ff[i-1];
      end
   end

   logic signed [PW-1:0] post [9];
   logic [FracBits+4:0] rho_d_ff [7];
   logic signed [PW-1:0] ux_d_ff [7], uy_d_ff [7];
   always_ff @(posedge clock) begin
      if (en) begin
         rho_d_ff[0] <= rho; ux_d_ff[0] <= ux; uy_d_ff[0] <= uy;
         for (int i = 1; i < 7; i++) begin
            rho_d_ff[i] <= rho_d_ff[i-1]; ux_d_ff[i] <= ux_d_ff[i-1];
            uy_d_ff[i] <= uy_d_ff[i-1];
         end
      end
   end

   for (genvar q = 0; q < 9; q++) begin : g_lane
      lbm_bgk_lane #(.FracBits(FracBits), .Cx(DirCx[q]), .Cy(DirCy[q]),
                     .WNum(q == 0 ? 4 : 1), .WDen(q == 0 ? 9 : (q < 5 ? 9 : 36))) u_lane (
         .clock(clock), .en(en), .f(fd_ff[MD-1][q*FW +: FW]), .rho(rho), .ux(ux), .uy(uy),
         .omega(relax_ff), .post(post[q]));
   end

   // Merge: lanes plus moments into one result beat.
   assign rsp.valid = vld_ff[Lat-1];
   always_comb begin
      rsp.data = '0;
      for (int q = 0; q < 9; q++) rsp.data[q*PW +: PW] = post[q];
      rsp.data[9*PW +: FracBits+5] = rho_d_ff[6];
      rsp.data[9*PW+FracBits+5 +: PW] = ux_d_ff[6];
      rsp.data[9*PW+FracBits+5+PW +: PW] = uy_d_ff[6];
   end

   `LBM_ASSERT(a_stall_hold, clock, reset, (rsp.valid && !rsp.ready) |=> rsp.valid)
   `LBM_ASSERT(a_ready_free, clock, reset, !rsp.valid |-> req.ready)
   `LBM_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp.valid)
endmodule

[tb/tb.sv]
// Testbench for the D2Q9 BGK collision unit: predictor, scoreboard and drivers.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lbm_bgk_pkg::*;

   localparam int InW   = 17;
   localparam int OutW  = 18;
   localparam int RhoW  = 21;
   localparam int ReqW  = NumDir * InW;
   localparam int RspW  = NumDir * OutW + RhoW + 2 * OutW;
   localparam longint One = longint'(1) << FracBits;
   localparam longint SatHi = 2 * One - 1;
   localparam longint SatLo = -2 * One;
   localparam int Latency = 2 + FracBits + 6 + 7;
   localparam int StallLimit = 20000;
   localparam int HoldCycles = 400;
   localparam int ItemsPerPhase = 450;

   typedef logic [InW-1:0] dist_type [NumDir];

   // one expected rsp beat
   typedef struct {
      logic [OutW-1:0] post [NumDir];
      logic [RhoW-1:0] density;
      logic [OutW-1:0] vel_x;
      logic [OutW-1:0] vel_y;
   } cell_result_type;

   // floor division, d > 0
   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   // nearest, ties toward +inf
   function automatic longint round_quot(longint n, longint d);
      return floor_quot(n + d / 2, d);
   endfunction

   function automatic longint clip_q(longint v);
      return (v > SatHi) ? SatHi : (v < SatLo) ? SatLo : v;
   endfunction

   class collision_scoreboard;
      cell_result_type pending_cells [$];
      logic [17:0]  omega;
      int           mismatches;
      int           checked;

      function new();
         omega = 18'(One);
         mismatches = 0;
         checked = 0;
      endfunction

      // predict the collision of one accepted cell
      function void note_cell(dist_type f);
         cell_result_type r;
         longint fv [NumDir];
         longint rho, mx, my, ux, uy, usq, e, poly, feq, post, wn, wd;
         rho = 0; mx = 0; my = 0; ux = 0; uy = 0;
         for (int q = 0; q < NumDir; q++) begin
            fv[q] = longint'(f[q]);
            rho += fv[q];
            mx += fv[q] * DirCx[q];
            my += fv[q] * DirCy[q];
         end
         if (rho > 0) begin
            ux = clip_q(round_quot(mx * One, rho));
            uy = clip_q(round_quot(my * One, rho));
         end
         usq = ux * ux + uy * uy;
         for (int q = 0; q < NumDir; q++) begin
            wn = (q == 0) ? 4 : 1;
            wd = (q == 0 || q < 5) ? 9 : 36;
            e = DirCx[q] * ux + DirCy[q] * uy;
            poly = One + 3 * e + round_quot(9 * e * e - 3 * usq, 2 * One);
            feq = round_quot(wn * rho * poly, wd * One);
            post = fv[q] + round_quot(longint'(omega) * (feq - fv[q]), One);
            r.post[q] = OutW'(clip_q(post));
         end
         r.density = RhoW'(rho);
         r.vel_x = OutW'(ux);
         r.vel_y = OutW'(uy);
         pending_cells.push_back(r);
      endfunction

      function void check_beat(logic [RspW-1:0] d);
         cell_result_type x;
         logic [OutW-1:0] gp;
         bit bad;
         checked++;
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("rsp beat with no cell pending: %h", d);
            return;
         end
         x = pending_cells.pop_front();
         bad = 0;
         for (int q = 0; q < NumDir; q++) begin
            gp = d[q*OutW +: OutW];
            if (gp !== x.post[q]) begin
               bad = 1;
               if (mismatches < 10)
                  $display("post[%0d]: expected %h got %h", q, x.post[q], gp);
            end
         end
         if (d[NumDir*OutW +: RhoW] !== x.density) begin
            bad = 1;
            if (mismatches < 10)
               $display("density: expected %h got %h", x.density, d[NumDir*OutW +: RhoW]);
         end
         if (d[NumDir*OutW+RhoW +: OutW] !== x.vel_x) begin
            bad = 1;
            if (mismatches < 10)
               $display("vel_x: expected %h got %h", x.vel_x, d[NumDir*OutW+RhoW +: OutW]);
         end
         if (d[NumDir*OutW+RhoW+OutW +: OutW] !== x.vel_y) begin
            bad = 1;
            if (mismatches < 10)
               $display("vel_y: expected %h got %h", x.vel_y,
                        d[NumDir*OutW+RhoW+OutW +: OutW]);
         end
         if (bad) mismatches++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CsrAddrWidth+1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   lbm_bgk_if #(.Width(ReqW)) req_ch (.clock(clock));
   lbm_bgk_if #(.Width(RspW)) rsp_ch (.clock(clock));

   lattice_boltzmann_bgk_collision_unit dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   collision_scoreboard sb = new();
   int  req_idle_pct = 0;   // sender gap odds, percent
   int  rsp_stall_pct = 0;  // receiver stall odds, percent
   bit  hold_go = 0;        // one long receiver hold-off
   int  hold_count = 0;
   int  quiet_cycles = 0;
   int  cells_sent = 0;
   int  csr_writes = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver: random stalls, plus a single long hold counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_go && hold_count < HoldCycles) begin
         hold_count <= hold_count + 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // rsp monitor: a beat moves when valid and ready are both high at the edge
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_beat(rsp_ch.data);
   end

   // watchdog on cycles where no beat moves
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("timeout: %0d cells still pending", sb.pending_cells.size());
         $display("[lattice_boltzmann_bgk_collision_unit] ERROR");
         $finish;
      end
   end

   function automatic logic [ReqW-1:0] pack_cell(dist_type f);
      logic [ReqW-1:0] d;
      for (int q = 0; q < NumDir; q++) d[q*InW +: InW] = f[q];
      return d;
   endfunction

   // offer one cell with random gaps ahead of it, wait for acceptance
   task automatic send_cell(dist_type f);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= pack_cell(f);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_cell(f);
      cells_sent++;
   endtask

   task automatic go_idle();
      req_ch.valid <= 1'b0;
      while (sb.pending_cells.size() != 0) @(posedge clock);
      repeat (Latency + 8) @(posedge clock);
   endtask

   task automatic write_relax_rate(logic [31:0] value);
      go_idle();
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {RegRelaxRate, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      sb.omega = value[17:0];
      csr_writes++;
      @(posedge clock);
      // read back what was stored
      if (!csr_pready || csr_prdata !== 32'(value[17:0])) begin
         sb.mismatches++;
         if (sb.mismatches <= 10)
            $display("relax_rate readback: expected %h got %h", value[17:0], csr_prdata);
      end
   endtask

   // random cell: mostly near equilibrium, the rest raw or edge noise
   function automatic dist_type random_cell();
      dist_type f;
      int mode, rho0, base, v;
      mode = $urandom_range(9);
      rho0 = $urandom_range(1, 9 * 65536);
      for (int q = 0; q < NumDir; q++) begin
         base = (q == 0) ? rho0 * 4 / 9 : (q < 5) ? rho0 / 9 : rho0 / 36;
         case (mode)
            0, 1, 2, 3, 4, 5: begin
               v = base + $urandom_range(8192) - 4096;
               f[q] = (v < 0) ? '0 : (v > 131071) ? 17'h1ffff : InW'(v);
            end
            6, 7: f[q] = InW'($urandom);
            8: f[q] = $urandom_range(1) ? InW'($urandom) : '0;
            default: f[q] = $urandom_range(1) ? 17'h1ffff : '0;
         endcase
      end
      return f;
   endfunction

   task automatic send_directed();
      dist_type f;
      foreach (f[q]) f[q] = '0;
      send_cell(f);                      // zero density
      foreach (f[q]) f[q] = 17'h1ffff;
      send_cell(f);                      // largest density
      for (int d = 0; d < NumDir; d++) begin
         foreach (f[q]) f[q] = '0;
         f[d] = 17'h1ffff;               // all mass in one direction: u components are 0 or +/-1
         send_cell(f);
      end
      foreach (f[q]) f[q] = (q == 0) ? 17'd29127 : (q < 5) ? 17'd7282 : 17'd1820;
      send_cell(f);                      // fluid at rest, near equilibrium
      foreach (f[q]) f[q] = 17'd1;
      send_cell(f);
      foreach (f[q]) f[q] = '0;
      f[0] = 17'h1ffff; f[3] = 17'd1;    // velocity exactly -1/2 lsb: tie
      send_cell(f);
      f[3] = '0; f[1] = 17'd1;           // and the positive tie
      send_cell(f);
   endtask

   task automatic random_phase(int n, int idle, int stall);
      req_idle_pct = idle;
      rsp_stall_pct = stall;
      repeat (n) send_cell(random_cell());
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default omega of 1.0 first, then directed cells at the extremes
      send_directed();
      write_relax_rate(32'd0);
      send_directed();
      write_relax_rate(32'd131072);
      send_directed();
      write_relax_rate(32'h3ffff);       // omega beyond 2.0, no clamp
      send_directed();
      write_relax_rate(32'hfffd_0000 | 32'd98304); // upper bits dropped

      // long receiver hold while the sender keeps offering: pipeline fills
      hold_go = 1;
      random_phase(ItemsPerPhase, 0, 0);
      go_idle();                         // sender waits for every result

      write_relax_rate(32'd65536);
      random_phase(ItemsPerPhase, 85, 0);
      write_relax_rate($urandom_range(131072));
      random_phase(ItemsPerPhase, 0, 85);
      write_relax_rate($urandom_range(262143));
      random_phase(ItemsPerPhase, 16, 16);

      go_idle();
      $display("covered %0d cells, %0d omega writes, %0d result beats checked",
               cells_sent, csr_writes, sb.checked);
      $display("zero density, saturating directions and stall phases included");
      if (sb.mismatches == 0) begin
         $display("[lattice_boltzmann_bgk_collision_unit] OK");
      end else begin
         $display("%0d mismatching beats", sb.mismatches);
         $display("[lattice_boltzmann_bgk_collision_unit] ERROR");
      end
      $finish;
   end
endmodule
